FILE: design/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

    localparam int SW   = 32;
    localparam int CW   = 34;
    localparam int ZW   = 35;
    localparam int SQW  = 62;
    localparam int RTW  = 31;
    localparam int MAXC = 32;

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [15:0]   LIM_PI      = 16'sd25736;
    localparam logic signed [15:0]   LIM_HALF_PI = 16'sd12868;

    localparam logic [30:0] ATAN_TAB [MAXC] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
        31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
        31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
    };

    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        lane_t                roll;
        lane_t                yaw;
        logic signed [SW-1:0] c;
        logic                 pzero;
    } side_t;

    typedef struct packed {
        lane_t roll;
        lane_t yaw;
        lane_t pitch;
    } tri_t;

    function automatic logic [5:0] lead_pos(input logic [63:0] m);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic logic signed [SW-1:0] scale_v(input logic signed [63:0] v,
                                                     input logic signed [7:0] sh);
        logic signed [63:0] t;
        logic [7:0]         nsh;
        nsh = -sh;
        if (sh >= 0) begin
            t = v <<< sh[5:0];
        end else begin
            t = v >>> nsh[5:0];
        end
        return t[SW-1:0];
    endfunction

    function automatic lane_t fold(input logic signed [SW-1:0] x,
                                   input logic signed [SW-1:0] y, input logic zero);
        lane_t l;
        l.zero = zero;
        l.x    = CW'(x);
        l.y    = CW'(y);
        l.z    = '0;
        if (x < 0) begin
            l.z = (y >= 0) ? PI_Q30 : -PI_Q30;
            l.x = -CW'(x);
            l.y = -CW'(y);
        end
        return l;
    endfunction

    function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                  input logic signed [15:0] lim);
        logic signed [ZW-1:0] t;
        t = (z + ZW'(65536)) >>> 17;
        if (t > ZW'(lim)) begin
            t = ZW'(lim);
        end
        if (t < -ZW'(lim)) begin
            t = -ZW'(lim);
        end
        return t[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/q2e_sqrt_cell.sv
`default_nettype none
module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire logic [SQW-1:0] rem_in,
    input  wire logic [RTW-1:0] root_in,
    input  wire side_t          side_in,
    output logic      [SQW-1:0] rem_out,
    output logic      [RTW-1:0] root_out,
    output side_t               side_out
);

    logic [SQW-1:0] trial;
    logic [SQW-1:0] rem_next;
    logic [RTW-1:0] root_next;

    always_comb begin
        trial     = (SQW'(root_in) << (K + 1)) + (SQW'(1) << (2 * K));
        rem_next  = rem_in;
        root_next = root_in;
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = root_in | (RTW'(1) << K);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out  <= rem_next;
            root_out <= root_next;
            side_out <= side_in;
        end
    end

endmodule
`default_nettype wire

FILE: design/q2e_cordic_cell.sv
`default_nettype none
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic aclk,
    input  wire logic en,
    input  wire tri_t lanes_in,
    output tri_t      lanes_out
);

    function automatic lane_t rotate(input lane_t l);
        lane_t                r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] da;
        dx = l.y >>> IDX;
        dy = l.x >>> IDX;
        da = signed'(ZW'(ATAN_TAB[IDX]));
        r  = l;
        if (l.y > 0) begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + da;
        end else begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - da;
        end
        return r;
    endfunction

    tri_t lanes_next;

    always_comb begin
        lanes_next.roll  = rotate(lanes_in.roll);
        lanes_next.yaw   = rotate(lanes_in.yaw);
        lanes_next.pitch = rotate(lanes_in.pitch);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lanes_out <= lanes_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/quaternion_to_euler_angles.sv
// Quaternion (w,x,y,z, signed Q1.15) to ZYX Euler angles (roll, pitch, yaw,
// signed Q3.13 radians).
// Input channel s_valid/s_ready carries one quaternion per item; result
// channel m_valid/m_ready carries roll, pitch and yaw of that item.
// Pipeline: eight front stages (products, matrix entries, normalization,
// squares), a 31-cell square-root chain, one rescale stage, one CORDIC
// cell per stage (16 stages at the default) and an output register.
// Throughput: one item per cycle; every stage is a register with its own
// valid bit, so the pipeline takes an item each cycle while it flows.
// Stall: when m_ready is low the output register holds; stages behind it
// keep advancing into empty slots and s_ready drops only once the whole
// pipeline is full.
// Reset: aresetn (synchronous, active low) clears all valid bits; the
// pipeline is empty and ready in the first cycle after reset.
`default_nettype none
module quaternion_to_euler_angles
    import q2e_pkg::*;
#(
    parameter int QUAT_WIDTH    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [QUAT_WIDTH-1:0] s_quat_w,
    input  wire logic signed [QUAT_WIDTH-1:0] s_quat_x,
    input  wire logic signed [QUAT_WIDTH-1:0] s_quat_y,
    input  wire logic signed [QUAT_WIDTH-1:0] s_quat_z,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [15:0]                m_roll_angle,
    output logic signed [14:0]                m_pitch_angle,
    output logic signed [15:0]                m_yaw_angle
);

    localparam int IW     = (QUAT_WIDTH > 30) ? 30 : QUAT_WIDTH;
    localparam int SHV    = QUAT_WIDTH - IW;
    localparam int PW     = 2 * IW;
    localparam int RW     = 2 * IW + 2;
    localparam int NC     = (CORDIC_STAGES > MAXC) ? MAXC : CORDIC_STAGES;
    localparam int ST_SQ0 = 8;
    localparam int ST_PN  = ST_SQ0 + RTW;
    localparam int ST_CD0 = ST_PN + 1;
    localparam int ST_OUT = ST_CD0 + NC;
    localparam int NST    = ST_OUT + 1;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    always_comb begin
        rdy[NST-1] = m_ready | ~v_reg[NST-1];
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = rdy[i+1] | ~v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NST-1];

    // stage 0: inputs
    logic signed [IW-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [QUAT_WIDTH-1:0] w_sh, x_sh, y_sh, z_sh;

    assign w_sh = s_quat_w >>> SHV;
    assign x_sh = s_quat_x >>> SHV;
    assign y_sh = s_quat_y >>> SHV;
    assign z_sh = s_quat_z >>> SHV;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            w_reg <= signed'(w_sh[IW-1:0]);
            x_reg <= signed'(x_sh[IW-1:0]);
            y_reg <= signed'(y_sh[IW-1:0]);
            z_reg <= signed'(z_sh[IW-1:0]);
        end
    end

    // stage 1: products
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [PW-1:0] wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            ww_reg <= w_reg * w_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            wz_reg <= w_reg * z_reg;
            xz_reg <= x_reg * z_reg;
            wy_reg <= w_reg * y_reg;
            yz_reg <= y_reg * z_reg;
            wx_reg <= w_reg * x_reg;
        end
    end

    // stage 2: matrix entries
    logic signed [RW-1:0] s2_r00_reg, s2_r10_reg, s2_r20_reg, s2_r21_reg, s2_r22_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s2_r00_reg <= RW'(ww_reg) + RW'(xx_reg) - RW'(yy_reg) - RW'(zz_reg);
            s2_r10_reg <= (RW'(xy_reg) + RW'(wz_reg)) <<< 1;
            s2_r20_reg <= (RW'(xz_reg) - RW'(wy_reg)) <<< 1;
            s2_r21_reg <= (RW'(yz_reg) + RW'(wx_reg)) <<< 1;
            s2_r22_reg <= RW'(ww_reg) - RW'(xx_reg) - RW'(yy_reg) + RW'(zz_reg);
        end
    end

    // stage 3: largest magnitudes
    logic [RW-1:0] a00, a10, a20, a21, a22;
    logic [RW-1:0] mp_next, my_next, mr_next;
    logic [RW-1:0] mp_reg, my_reg, mr_reg;
    logic signed [RW-1:0] s3_r00_reg, s3_r10_reg, s3_r20_reg, s3_r21_reg, s3_r22_reg;

    always_comb begin
        a00 = s2_r00_reg[RW-1] ? RW'(-s2_r00_reg) : RW'(s2_r00_reg);
        a10 = s2_r10_reg[RW-1] ? RW'(-s2_r10_reg) : RW'(s2_r10_reg);
        a20 = s2_r20_reg[RW-1] ? RW'(-s2_r20_reg) : RW'(s2_r20_reg);
        a21 = s2_r21_reg[RW-1] ? RW'(-s2_r21_reg) : RW'(s2_r21_reg);
        a22 = s2_r22_reg[RW-1] ? RW'(-s2_r22_reg) : RW'(s2_r22_reg);
        my_next = (a10 > a00) ? a10 : a00;
        mp_next = (a20 > my_next) ? a20 : my_next;
        mr_next = (a21 > a22) ? a21 : a22;
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            mp_reg     <= mp_next;
            my_reg     <= my_next;
            mr_reg     <= mr_next;
            s3_r00_reg <= s2_r00_reg;
            s3_r10_reg <= s2_r10_reg;
            s3_r20_reg <= s2_r20_reg;
            s3_r21_reg <= s2_r21_reg;
            s3_r22_reg <= s2_r22_reg;
        end
    end

    // stage 4: normalizing shifts
    logic signed [7:0] shp_reg, shy_reg, shr_reg;
    logic              zp_reg, zy_reg, zr_reg;
    logic signed [RW-1:0] s4_r00_reg, s4_r10_reg, s4_r20_reg, s4_r21_reg, s4_r22_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            shp_reg    <= 8'sd29 - signed'({2'b00, lead_pos(64'(mp_reg))});
            shy_reg    <= 8'sd29 - signed'({2'b00, lead_pos(64'(my_reg))});
            shr_reg    <= 8'sd29 - signed'({2'b00, lead_pos(64'(mr_reg))});
            zp_reg     <= (mp_reg == '0);
            zy_reg     <= (my_reg == '0);
            zr_reg     <= (mr_reg == '0);
            s4_r00_reg <= s3_r00_reg;
            s4_r10_reg <= s3_r10_reg;
            s4_r20_reg <= s3_r20_reg;
            s4_r21_reg <= s3_r21_reg;
            s4_r22_reg <= s3_r22_reg;
        end
    end

    // stage 5: scaling
    logic signed [SW-1:0] s5_a_reg, s5_b_reg, s5_c_reg;
    logic signed [SW-1:0] s5_rx_reg, s5_ry_reg, s5_yx_reg, s5_yy_reg;
    logic                 s5_zp_reg, s5_zy_reg, s5_zr_reg;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            s5_a_reg  <= scale_v(64'(s4_r00_reg), shp_reg);
            s5_b_reg  <= scale_v(64'(s4_r10_reg), shp_reg);
            s5_c_reg  <= scale_v(64'(s4_r20_reg), shp_reg);
            s5_rx_reg <= scale_v(64'(s4_r22_reg), shr_reg);
            s5_ry_reg <= scale_v(64'(s4_r21_reg), shr_reg);
            s5_yx_reg <= scale_v(64'(s4_r00_reg), shy_reg);
            s5_yy_reg <= scale_v(64'(s4_r10_reg), shy_reg);
            s5_zp_reg <= zp_reg;
            s5_zy_reg <= zy_reg;
            s5_zr_reg <= zr_reg;
        end
    end

    // stage 6: squares and half-plane fold
    logic signed [2*SW-1:0] ae, be;
    logic        [SQW-1:0]  aa_reg, bb_reg;
    side_t                  s6_side_next, s6_side_reg;

    always_comb begin
        ae                 = s5_a_reg * s5_a_reg;
        be                 = s5_b_reg * s5_b_reg;
        s6_side_next.roll  = fold(s5_rx_reg, s5_ry_reg, s5_zr_reg);
        s6_side_next.yaw   = fold(s5_yx_reg, s5_yy_reg, s5_zy_reg);
        s6_side_next.c     = s5_c_reg;
        s6_side_next.pzero = s5_zp_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            aa_reg      <= ae[SQW-1:0];
            bb_reg      <= be[SQW-1:0];
            s6_side_reg <= s6_side_next;
        end
    end

    // stage 7: sum of squares
    logic [SQW-1:0] sq_rem  [0:RTW];
    logic [RTW-1:0] sq_root [0:RTW];
    side_t          sq_side [0:RTW];

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            sq_rem[0]  <= aa_reg + bb_reg;
            sq_side[0] <= s6_side_reg;
        end
    end

    assign sq_root[0] = '0;

    for (genvar g = 0; g < RTW; g++) begin : g_sqrt
        q2e_sqrt_cell #(
            .K(RTW - 1 - g)
        ) u_cell (
            .aclk    (aclk),
            .en      (rdy[ST_SQ0+g]),
            .rem_in  (sq_rem[g]),
            .root_in (sq_root[g]),
            .side_in (sq_side[g]),
            .rem_out (sq_rem[g+1]),
            .root_out(sq_root[g+1]),
            .side_out(sq_side[g+1])
        );
    end

    // pitch operand rescale
    tri_t                 cd_lanes [0:NC];
    tri_t                 pn_next;
    logic signed [CW-1:0] nc;
    logic [RTW-1:0]       h;

    always_comb begin
        h                   = sq_root[RTW];
        nc                  = -CW'(sq_side[RTW].c);
        pn_next.roll        = sq_side[RTW].roll;
        pn_next.yaw         = sq_side[RTW].yaw;
        pn_next.pitch.zero  = sq_side[RTW].pzero;
        pn_next.pitch.z     = '0;
        if (h[RTW-1]) begin
            pn_next.pitch.x = CW'({1'b0, h} >> 1);
            pn_next.pitch.y = nc >>> 1;
        end else begin
            pn_next.pitch.x = CW'({1'b0, h});
            pn_next.pitch.y = nc;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_PN]) begin
            cd_lanes[0] <= pn_next;
        end
    end

    for (genvar g = 0; g < NC; g++) begin : g_cordic
        q2e_cordic_cell #(
            .IDX(g)
        ) u_cell (
            .aclk     (aclk),
            .en       (rdy[ST_CD0+g]),
            .lanes_in (cd_lanes[g]),
            .lanes_out(cd_lanes[g+1])
        );
    end

    // output register
    logic signed [15:0] pitch_full;

    assign pitch_full = to_q13(cd_lanes[NC].pitch.z, LIM_HALF_PI);

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            m_roll_angle  <= cd_lanes[NC].roll.zero ? '0
                                                    : to_q13(cd_lanes[NC].roll.z, LIM_PI);
            m_yaw_angle   <= cd_lanes[NC].yaw.zero ? '0
                                                   : to_q13(cd_lanes[NC].yaw.z, LIM_PI);
            m_pitch_angle <= cd_lanes[NC].pitch.zero ? '0 : pitch_full[14:0];
        end
    end

endmodule
`default_nettype wire
